// ----- rtl/core/nidv_pkg.sv -----
// ----------------------------------------------------------------------------
// nidv_pkg
// Shared types, codes and tables for the national ID validator with
// duplicate detection.
// ----------------------------------------------------------------------------
package nidv_pkg;

  // Fixed field widths
  localparam int unsigned KEY_W   = 41;
  localparam int unsigned COUNT_W = 16;
  localparam logic [3:0]  ID_LEN  = 4'd10;

  // Request operation codes
  localparam logic OP_CHAR  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Verdict codes
  localparam logic [1:0] VERDICT_NEW = 2'd0;
  localparam logic [1:0] VERDICT_DUP = 2'd1;
  localparam logic [1:0] VERDICT_BAD = 2'd2;

  // Character bounds
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

  typedef struct packed {
    logic       op;
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic [1:0]         verdict;
    logic               store_full;
    logic [COUNT_W-1:0] count_new;
    logic [COUNT_W-1:0] count_dup;
    logic [COUNT_W-1:0] count_bad;
  } out_t;

  // Lookup request travelling along the store chain
  typedef struct packed {
    logic             vld;
    logic             good;
    logic             hit;
    logic             stored;
    logic [KEY_W-1:0] key;
  } qry_t;

  // Letter contribution to the weighted sum, already reduced mod 10:
  // tens digit of the letter code with weight 1, units digit with weight 9
  function automatic logic [3:0] letter_res(input logic [4:0] idx);
    logic [3:0] r;
    unique case (idx)
      5'd0:    r = 4'd1;
      5'd1:    r = 4'd0;
      5'd2:    r = 4'd9;
      5'd3:    r = 4'd8;
      5'd4:    r = 4'd7;
      5'd5:    r = 4'd6;
      5'd6:    r = 4'd5;
      5'd7:    r = 4'd4;
      5'd8:    r = 4'd9;
      5'd9:    r = 4'd3;
      5'd10:   r = 4'd2;
      5'd11:   r = 4'd2;
      5'd12:   r = 4'd1;
      5'd13:   r = 4'd0;
      5'd14:   r = 4'd8;
      5'd15:   r = 4'd9;
      5'd16:   r = 4'd8;
      5'd17:   r = 4'd7;
      5'd18:   r = 4'd6;
      5'd19:   r = 4'd5;
      5'd20:   r = 4'd4;
      5'd21:   r = 4'd3;
      5'd22:   r = 4'd1;
      5'd23:   r = 4'd3;
      5'd24:   r = 4'd2;
      5'd25:   r = 4'd0;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // Weight of the digit at a given character position
  function automatic logic [3:0] digit_weight(input logic [3:0] pos);
    logic [3:0] w;
    unique case (pos)
      4'd1:    w = 4'd8;
      4'd2:    w = 4'd7;
      4'd3:    w = 4'd6;
      4'd4:    w = 4'd5;
      4'd5:    w = 4'd4;
      4'd6:    w = 4'd3;
      4'd7:    w = 4'd2;
      4'd8:    w = 4'd1;
      4'd9:    w = 4'd1;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

  // Reduce a value below 128 modulo 10 by conditional subtraction
  function automatic logic [3:0] mod10_fold(input logic [6:0] v);
    logic [6:0] t;
    t = v;
    if (t >= 7'd80) t = t - 7'd80;
    if (t >= 7'd40) t = t - 7'd40;
    if (t >= 7'd20) t = t - 7'd20;
    if (t >= 7'd10) t = t - 7'd10;
    return t[3:0];
  endfunction

endpackage

// ----- rtl/core/nidv_tok.sv -----
// ----------------------------------------------------------------------------
// nidv_tok
// Token front end: checks characters, keeps the check sum mod 10 and packs
// the ID key; issues one lookup request at each token end.
// ----------------------------------------------------------------------------
module nidv_tok (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic              clr,
  input  logic [7:0]        char_code,
  input  logic              last_char,
  output nidv_pkg::qry_t    qry
);

  logic [3:0]                 pos_r, pos_nxt;
  logic                       bad_r, bad_nxt;
  logic [3:0]                 sum_r, sum_nxt;
  logic [nidv_pkg::KEY_W-1:0] key_r, key_nxt;

  logic       is_upper;
  logic       is_digit;
  logic [7:0] letter_off;
  logic [4:0] letter_idx;
  logic [3:0] digit;
  logic [7:0] term;

  // Classify the character
  assign is_upper   = (char_code >= nidv_pkg::CHAR_UPPER_A) &&
                      (char_code <= nidv_pkg::CHAR_UPPER_Z);
  assign is_digit   = (char_code >= nidv_pkg::CHAR_DIGIT_0) &&
                      (char_code <= nidv_pkg::CHAR_DIGIT_9);
  assign letter_off = char_code - nidv_pkg::CHAR_UPPER_A;
  assign letter_idx = letter_off[4:0];
  assign digit      = char_code[3:0];
  assign term       = {4'b0000, digit} * {4'b0000, nidv_pkg::digit_weight(pos_r)};

  // Advance the token state by one character
  always_comb begin
    pos_nxt = pos_r;
    bad_nxt = bad_r;
    sum_nxt = sum_r;
    key_nxt = key_r;
    if (pos_r >= nidv_pkg::ID_LEN) begin
      bad_nxt = 1'b1;
    end else if (pos_r == 4'd0) begin
      if (is_upper) begin
        sum_nxt = nidv_pkg::letter_res(letter_idx);
        key_nxt = {{(nidv_pkg::KEY_W-5){1'b0}}, letter_idx};
      end else begin
        bad_nxt = 1'b1;
      end
      pos_nxt = pos_r + 4'd1;
    end else begin
      if (is_digit) begin
        if ((pos_r == 4'd1) && (digit != 4'd1) && (digit != 4'd2)) begin
          bad_nxt = 1'b1;
        end
        sum_nxt = nidv_pkg::mod10_fold({3'b000, sum_r} + term[6:0]);
        key_nxt = {key_r[nidv_pkg::KEY_W-5:0], digit};
      end else begin
        bad_nxt = 1'b1;
      end
      pos_nxt = pos_r + 4'd1;
    end
  end

  // Issue the lookup request at token end
  always_comb begin
    qry.vld    = take && last_char;
    qry.good   = !bad_nxt && (pos_nxt == nidv_pkg::ID_LEN) && (sum_nxt == 4'd0);
    qry.hit    = 1'b0;
    qry.stored = 1'b0;
    qry.key    = key_nxt;
  end

  // Hold token state; drop it on clear or token end
  always_ff @(posedge clk) begin
    if (!rst_n || clr || (take && last_char)) begin
      pos_r <= 4'd0;
      bad_r <= 1'b0;
      sum_r <= 4'd0;
      key_r <= '0;
    end else if (take) begin
      pos_r <= pos_nxt;
      bad_r <= bad_nxt;
      sum_r <= sum_nxt;
      key_r <= key_nxt;
    end
  end

endmodule

// ----- rtl/core/nidv_cell.sv -----
// ----------------------------------------------------------------------------
// nidv_cell
// One store entry of the lookup chain: compares the passing request with
// its key, claims the request's key if it is the first free entry reached
// by a miss, and hands the request on to the next cell.
// ----------------------------------------------------------------------------
module nidv_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           clr,
  input  nidv_pkg::qry_t qry_in,
  output nidv_pkg::qry_t qry_out
);

  logic                       used_r;
  logic [nidv_pkg::KEY_W-1:0] key_r;
  nidv_pkg::qry_t             qry_r, qry_nxt;
  logic                       match;
  logic                       claim;

  assign match = used_r && (key_r == qry_in.key);
  assign claim = qry_in.vld && qry_in.good && !used_r && !qry_in.hit && !qry_in.stored;

  // Mark hit or store on the request
  always_comb begin
    qry_nxt = qry_in;
    if (qry_in.vld && qry_in.good && match) begin
      qry_nxt.hit = 1'b1;
    end
    if (claim) begin
      qry_nxt.stored = 1'b1;
    end
  end

  // Advance the request and hold the entry valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      qry_r  <= '0;
    end else begin
      if (adv) begin
        qry_r <= qry_nxt;
      end
      if (clr) begin
        used_r <= 1'b0;
      end else if (adv && claim) begin
        used_r <= 1'b1;
      end
    end
  end

  // Key of the entry
  always_ff @(posedge clk) begin
    if (adv && claim) begin
      key_r <= qry_in.key;
    end
  end

  assign qry_out = qry_r;

endmodule

// ----- rtl/core/national_id_validator_dedup.sv -----
// ----------------------------------------------------------------------------
// national_id_validator_dedup
// Ten-character national ID checker with a batch store of accepted IDs.
// ----------------------------------------------------------------------------
// Characters are taken one per cycle unless a result is stalled. Each token end
// sends a lookup request into a chain of STORE_DEPTH store cells, one cell per
// cycle, and its result (verdict, store-full flag, saturating batch counts) is
// registered as it leaves the last cell. Further characters and token ends keep
// flowing in behind it, one per cycle unless a result is stalled. A clear request
// waits until all lookups in the chain have left it, and output backpressure
// stalls the whole chain. Store entries are filled in arrival order; once all
// are used, new IDs are reported with store_full set and are not kept.
module national_id_validator_dedup #(
  parameter int unsigned STORE_DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  nidv_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output nidv_pkg::out_t out_data
);

  localparam int unsigned FLIGHT_W = $clog2(STORE_DEPTH + 1);

  nidv_pkg::qry_t link [STORE_DEPTH+1];
  nidv_pkg::qry_t exit_q;

  logic                         adv;
  logic                         take;
  logic                         clr;
  logic                         enter;
  logic                         leave;
  logic [FLIGHT_W-1:0]          flight_r, flight_nxt;
  logic                         out_valid_r;
  nidv_pkg::out_t               out_r, out_nxt;
  logic [nidv_pkg::COUNT_W-1:0] cnt_new_r, cnt_new_nxt;
  logic [nidv_pkg::COUNT_W-1:0] cnt_dup_r, cnt_dup_nxt;
  logic [nidv_pkg::COUNT_W-1:0] cnt_bad_r, cnt_bad_nxt;

  // Stall the chain only while a result waits
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv && ((in_data.op == nidv_pkg::OP_CHAR) || (flight_r == '0));
  assign take     = in_valid && in_ready && (in_data.op == nidv_pkg::OP_CHAR);
  assign clr      = in_valid && in_ready && (in_data.op == nidv_pkg::OP_CLEAR);
  assign exit_q   = link[STORE_DEPTH];
  assign enter    = link[0].vld;
  assign leave    = adv && exit_q.vld;

  nidv_tok u_tok (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .clr       (clr),
    .char_code (in_data.char_code),
    .last_char (in_data.last_char),
    .qry       (link[0])
  );

  // Row of store cells
  for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_cell
    nidv_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .clr     (clr),
      .qry_in  (link[g]),
      .qry_out (link[g+1])
    );
  end

  // Track lookups in the chain
  always_comb begin
    flight_nxt = flight_r;
    if (enter && !leave) begin
      flight_nxt = flight_r + FLIGHT_W'(1);
    end else if (!enter && leave) begin
      flight_nxt = flight_r - FLIGHT_W'(1);
    end
  end

  // Form the result of the lookup leaving the chain
  always_comb begin
    cnt_new_nxt        = cnt_new_r;
    cnt_dup_nxt        = cnt_dup_r;
    cnt_bad_nxt        = cnt_bad_r;
    out_nxt.store_full = 1'b0;
    priority if (!exit_q.good) begin
      out_nxt.verdict = nidv_pkg::VERDICT_BAD;
      if (cnt_bad_r != '1) cnt_bad_nxt = cnt_bad_r + 1'b1;
    end else if (exit_q.hit) begin
      out_nxt.verdict = nidv_pkg::VERDICT_DUP;
      if (cnt_dup_r != '1) cnt_dup_nxt = cnt_dup_r + 1'b1;
    end else begin
      out_nxt.verdict    = nidv_pkg::VERDICT_NEW;
      out_nxt.store_full = !exit_q.stored;
      if (cnt_new_r != '1) cnt_new_nxt = cnt_new_r + 1'b1;
    end
    out_nxt.count_new = cnt_new_nxt;
    out_nxt.count_dup = cnt_dup_nxt;
    out_nxt.count_bad = cnt_bad_nxt;
  end

  // Hold control state and counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flight_r    <= '0;
      out_valid_r <= 1'b0;
      cnt_new_r   <= '0;
      cnt_dup_r   <= '0;
      cnt_bad_r   <= '0;
    end else begin
      flight_r <= flight_nxt;
      if (adv) begin
        out_valid_r <= exit_q.vld;
      end
      if (clr) begin
        cnt_new_r <= '0;
        cnt_dup_r <= '0;
        cnt_bad_r <= '0;
      end else if (leave) begin
        cnt_new_r <= cnt_new_nxt;
        cnt_dup_r <= cnt_dup_nxt;
        cnt_bad_r <= cnt_bad_nxt;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (leave) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_clear_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    clr |-> (flight_r == '0))
    else $error("clear taken with lookups in flight");

  a_flight_bound : assert property (@(posedge clk) disable iff (!rst_n)
    flight_r <= FLIGHT_W'(STORE_DEPTH))
    else $error("in-flight count exceeds chain length");

  a_full_only_new : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.store_full) |-> (out_data.verdict == nidv_pkg::VERDICT_NEW))
    else $error("store_full on a non-new verdict");

  a_stall_holds_chain : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(flight_r))
    else $error("chain moved while the result was stalled");
`endif

endmodule

// ----- tb/sv/nidv_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nidv_result_checker
// Watches the request and result channels of the ID validator, keeps its own model of
// the token state, the batch store and the saturating counts, and compares
// every result against the oldest verdict still awaited.
// ----------------------------------------------------------------------------
module nidv_result_checker #(
  parameter int unsigned STORE_DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  nidv_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  nidv_pkg::out_t out_data,
  output int unsigned    fail_count,
  output int unsigned    pending
);
  import nidv_pkg::*;

  localparam int unsigned REPORT_LIMIT = 30;
  localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

  // Token being assembled
  logic [3:0]       char_pos;
  logic             token_bad;
  logic [8:0]       wsum;
  logic [KEY_W-1:0] id_key;

  // Batch store and counts
  logic [KEY_W-1:0]   stored_key [0:STORE_DEPTH-1];
  int unsigned        fill;
  logic [COUNT_W-1:0] new_cnt;
  logic [COUNT_W-1:0] dup_cnt;
  logic [COUNT_W-1:0] bad_cnt;

  out_t        expected_verdicts [$];
  int unsigned mismatches = 0;
  int unsigned reports = 0;

  // Two-digit code of each leading letter
  function automatic int unsigned letter_code(input logic [4:0] idx);
    int unsigned c;
    case (idx)
      5'd0:    c = 10;
      5'd1:    c = 11;
      5'd2:    c = 12;
      5'd3:    c = 13;
      5'd4:    c = 14;
      5'd5:    c = 15;
      5'd6:    c = 16;
      5'd7:    c = 17;
      5'd8:    c = 34;
      5'd9:    c = 18;
      5'd10:   c = 19;
      5'd11:   c = 20;
      5'd12:   c = 21;
      5'd13:   c = 22;
      5'd14:   c = 35;
      5'd15:   c = 23;
      5'd16:   c = 24;
      5'd17:   c = 25;
      5'd18:   c = 26;
      5'd19:   c = 27;
      5'd20:   c = 28;
      5'd21:   c = 29;
      5'd22:   c = 32;
      5'd23:   c = 30;
      5'd24:   c = 31;
      default: c = 33;
    endcase
    return c;
  endfunction

  // Digits at positions 1..8 weigh 8 down to 1; the check digit weighs 1
  function automatic int unsigned digit_wt(input logic [3:0] pos);
    return (pos <= 4'd8) ? 9 - pos : 1;
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    return (c == COUNT_TOP) ? c : c + 1'b1;
  endfunction

  task automatic clear_token();
    char_pos = '0;
    token_bad = 1'b0;
    wsum = '0;
    id_key = '0;
  endtask

  task automatic clear_batch();
    clear_token();
    fill = 0;
    new_cnt = '0;
    dup_cnt = '0;
    bad_cnt = '0;
  endtask

  // Fold one character into the token
  task automatic take_char(input logic [7:0] ch);
    logic [7:0]  off;
    logic [3:0]  d;
    int unsigned code;
    if (char_pos >= ID_LEN) begin
      token_bad = 1'b1;
    end else begin
      if (char_pos == 4'd0) begin
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
          off = ch - CHAR_UPPER_A;
          code = letter_code(off[4:0]);
          wsum = 9'(code / 10 + (code % 10) * 9);
          id_key = '0;
          id_key[4:0] = off[4:0];
        end else begin
          token_bad = 1'b1;
        end
      end else begin
        if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) begin
          off = ch - CHAR_DIGIT_0;
          d = off[3:0];
          if (char_pos == 4'd1 && d != 4'd1 && d != 4'd2) token_bad = 1'b1;
          wsum = 9'(wsum + d * digit_wt(char_pos));
          id_key = {id_key[KEY_W-5:0], d};
        end else begin
          token_bad = 1'b1;
        end
      end
      char_pos = char_pos + 1'b1;
    end
  endtask

  // Judge a finished token and queue its verdict
  task automatic close_token();
    out_t verdict;
    logic hit;
    int unsigned i;
    verdict = '0;
    if (token_bad || char_pos != ID_LEN || (wsum % 10) != 0) begin
      verdict.verdict = VERDICT_BAD;
      bad_cnt = sat_inc(bad_cnt);
    end else begin
      hit = 1'b0;
      for (i = 0; i < fill; i++) begin
        if (stored_key[i] == id_key) hit = 1'b1;
      end
      if (hit) begin
        verdict.verdict = VERDICT_DUP;
        dup_cnt = sat_inc(dup_cnt);
      end else begin
        verdict.verdict = VERDICT_NEW;
        new_cnt = sat_inc(new_cnt);
        if (fill < STORE_DEPTH) begin
          stored_key[fill] = id_key;
          fill++;
        end else begin
          verdict.store_full = 1'b1;
        end
      end
    end
    verdict.count_new = new_cnt;
    verdict.count_dup = dup_cnt;
    verdict.count_bad = bad_cnt;
    expected_verdicts.push_back(verdict);
    clear_token();
  endtask

  task automatic report_field(input string field, input int unsigned want,
                              input int unsigned seen);
    mismatches++;
    if (reports < REPORT_LIMIT) begin
      $display("%0t: %s expected %0d got %0d", $time, field, want, seen);
    end
    reports++;
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (expected_verdicts.size() == 0) begin
      mismatches++;
      if (reports < REPORT_LIMIT) begin
        $display("%0t: result with no token pending, expected none got verdict %0d",
                 $time, got.verdict);
      end
      reports++;
    end else begin
      want = expected_verdicts.pop_front();
      if (got.verdict != want.verdict)
        report_field("verdict", want.verdict, got.verdict);
      if (got.store_full != want.store_full)
        report_field("store_full", want.store_full, got.store_full);
      if (got.count_new != want.count_new)
        report_field("count_new", want.count_new, got.count_new);
      if (got.count_dup != want.count_dup)
        report_field("count_dup", want.count_dup, got.count_dup);
      if (got.count_bad != want.count_bad)
        report_field("count_bad", want.count_bad, got.count_bad);
    end
  endtask

  // Predict on every accepted request, then compare every accepted result
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_batch();
      expected_verdicts.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (in_data.op == OP_CLEAR) begin
          clear_batch();
        end else begin
          take_char(in_data.char_code);
          if (in_data.last_char) close_token();
        end
      end
      if (out_valid && out_ready) check_result(out_data);
    end
    fail_count <= mismatches;
    pending <= expected_verdicts.size();
  end

endmodule

// ----- tb/sv/national_id_validator_dedup_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// national_id_validator_dedup_tb
// Streams ID tokens into the validator: a short directed opening, then a
// random mix of valid, repeated and malformed tokens with clears, with one
// pause in the middle that lets every result come back.
// ----------------------------------------------------------------------------
module national_id_validator_dedup_tb;
  import nidv_pkg::*;

  localparam int unsigned STORE_DEPTH  = 256;
  localparam int unsigned RANDOM_ITEMS = 1020;
  localparam int unsigned DRAIN_CYCLES = STORE_DEPTH + 20;
  localparam int unsigned CYCLE_LIMIT  = 5_000_000;
  localparam int unsigned LOG_DEPTH    = 512;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  int unsigned fail_count;
  int unsigned pending;

  // Token under construction and log of sent valid IDs
  logic [7:0]  tok [0:15];
  int unsigned tok_len = 0;
  logic [79:0] id_log [0:LOG_DEPTH-1];
  int unsigned log_count = 0;

  int unsigned items_sent = 0;
  logic        send_idle = 1'b0;
  logic        recv_idle = 1'b0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;

  always #10 clk = ~clk;

  national_id_validator_dedup #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  nidv_result_checker #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 97) return $urandom_range(1, 4);
    return $urandom_range(10, 300);
  endfunction

  // Contribution of the leading letter to the checksum
  function automatic int unsigned letter_weight(input int unsigned idx);
    int unsigned code;
    if (idx < 8) code = idx + 10;
    else if (idx == 8) code = 34;
    else if (idx < 14) code = idx + 9;
    else if (idx == 14) code = 35;
    else if (idx < 22) code = idx + 8;
    else if (idx == 22) code = 32;
    else if (idx == 25) code = 33;
    else code = idx + 7;
    return code / 10 + (code % 10) * 9;
  endfunction

  // Stall the result channel at random
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (recv_idle && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("national_id_validator_dedup verification failed");
      $finish;
    end
  end

  // Offer one request, hold it until accepted, then maybe idle
  task automatic send_request(input logic req_op, input logic [7:0] ch, input logic last);
    in_t         req;
    int unsigned gap;
    req.op = req_op;
    req.char_code = ch;
    req.last_char = last;
    in_data <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    gap = send_idle ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every awaited result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_token();
    int unsigned k;
    for (k = 0; k < tok_len; k++) send_request(OP_CHAR, tok[k], k == tok_len - 1);
  endtask

  // Fill in the check digit from the first nine characters
  task automatic seal_id();
    int unsigned sum, k;
    sum = letter_weight(tok[0] - CHAR_UPPER_A);
    for (k = 1; k <= 8; k++) sum += (tok[k] - CHAR_DIGIT_0) * (9 - k);
    tok[9] = CHAR_DIGIT_0 + 8'((10 - sum % 10) % 10);
    tok_len = 10;
  endtask

  task automatic make_id(input int unsigned letter, input int unsigned gender);
    int unsigned k;
    tok[0] = CHAR_UPPER_A + 8'(letter);
    tok[1] = CHAR_DIGIT_0 + 8'(gender);
    for (k = 2; k <= 8; k++) tok[k] = CHAR_DIGIT_0 + 8'($urandom_range(0, 9));
    seal_id();
  endtask

  task automatic log_id();
    logic [79:0] v;
    int unsigned k;
    for (k = 0; k < 10; k++) v[8*k +: 8] = tok[k];
    id_log[log_count % LOG_DEPTH] = v;
    log_count++;
  endtask

  task automatic recall_id(input int unsigned idx);
    logic [79:0] v;
    int unsigned k;
    v = id_log[idx];
    for (k = 0; k < 10; k++) tok[k] = v[8*k +: 8];
    tok_len = 10;
  endtask

  // One random token: mostly well-formed, some broken, a few clears
  task automatic send_random_token();
    int unsigned kind, k, cut, logged;
    kind = $urandom_range(0, 99);
    logged = (log_count < LOG_DEPTH) ? log_count : LOG_DEPTH;
    if (kind < 55) begin
      if (kind >= 35 && logged != 0) begin
        recall_id($urandom_range(0, logged - 1));
      end else begin
        make_id($urandom_range(0, 25), $urandom_range(1, 2));
        log_id();
      end
    end else if (kind < 63) begin
      // wrong check digit
      make_id($urandom_range(0, 25), $urandom_range(1, 2));
      tok[9] = CHAR_DIGIT_0 + 8'((tok[9] - CHAR_DIGIT_0 + $urandom_range(1, 9)) % 10);
    end else if (kind < 68) begin
      // gender digit other than 1 or 2
      make_id($urandom_range(0, 25), $urandom_range(1, 2));
      k = $urandom_range(0, 7);
      tok[1] = (k == 0) ? CHAR_DIGIT_0 : CHAR_DIGIT_0 + 8'(k + 2);
    end else if (kind < 76) begin
      // any byte at any position
      make_id($urandom_range(0, 25), $urandom_range(1, 2));
      tok[$urandom_range(0, 9)] = 8'($urandom_range(0, 255));
    end else if (kind < 82) begin
      make_id($urandom_range(0, 25), $urandom_range(1, 2));
      tok_len = $urandom_range(1, 9);
    end else if (kind < 88) begin
      make_id($urandom_range(0, 25), $urandom_range(1, 2));
      tok_len = $urandom_range(11, 14);
      for (k = 10; k < tok_len; k++) tok[k] = CHAR_DIGIT_0 + 8'($urandom_range(0, 9));
    end else if (kind < 96) begin
      tok_len = $urandom_range(1, 12);
      for (k = 0; k < tok_len; k++) tok[k] = 8'($urandom_range(0, 255));
    end else begin
      // clear, sometimes cutting a token short
      tok_len = 0;
      if ($urandom_range(0, 1) == 1) begin
        make_id($urandom_range(0, 25), $urandom_range(1, 2));
        cut = $urandom_range(1, 9);
        for (k = 0; k < cut; k++) send_request(OP_CHAR, tok[k], 1'b0);
        tok_len = 0;
      end
      send_request(OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    send_token();
  endtask

  initial begin
    int unsigned random_start;
    logic        paused;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: clear, lowest letter new then duplicate, byte extremes
    send_request(OP_CLEAR, 8'hFF, 1'b1);
    make_id(0, 1);
    log_id();
    send_token();
    send_token();
    send_request(OP_CHAR, 8'h00, 1'b1);
    send_request(OP_CHAR, 8'hFF, 1'b1);
    send_request(OP_CLEAR, 8'h00, 1'b0);

    // Random mix with idling that changes in stretches
    random_start = items_sent;
    paused = 1'b0;
    while (items_sent < random_start + RANDOM_ITEMS) begin
      if ($urandom_range(0, 49) == 0) begin
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle <= ($urandom_range(0, 3) != 0);
      end
      if (!paused && items_sent >= random_start + RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        wait_drained();
      end
      send_random_token();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("national_id_validator_dedup verification clean");
    end else begin
      $display("national_id_validator_dedup verification failed");
    end
    $finish;
  end

endmodule
